// ===== rtl/core/fird2_pkg.sv =====
// ----------------------------------------------------------------------------
// fird2_pkg: shared types and constants of the decimate-by-two FIR
// Coefficient table, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package fird2_pkg;

    localparam int FIELD_CHANNELS     = 4;
    localparam int HALF_TAPS          = 12;
    localparam int COEF_W             = 16;
    localparam int COEF_FRAC          = 15;
    localparam int DEF_TAPS           = 24;
    localparam int DEF_CHANNELS       = 4;
    localparam int DEF_SAMPLE_WIDTH   = 16;

    // Q1.15 low-pass half set, tap 0 is the newest sample
    localparam logic signed [COEF_W-1:0] HALF_COEF [HALF_TAPS] = '{
        16'sd17,    -16'sd47,   -16'sd166,  -16'sd77,
        16'sd368,   16'sd667,   -16'sd16,   -16'sd1485,
        -16'sd1808, 16'sd1080,  16'sd6634,  16'sd11218
    };

    // symmetric lookup: taps beyond the half set read as zero
    function automatic logic signed [COEF_W-1:0] tap_coef(input int tap, input int taps);
        int mirror;
        int h;
        logic signed [COEF_W-1:0] c;
        mirror = taps - 1 - tap;
        h      = (tap < mirror) ? tap : mirror;
        c      = '0;
        if (h >= 0 && h < HALF_TAPS) begin
            c = HALF_COEF[h];
        end
        return c;
    endfunction

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MAC,
        S_FLUSH,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic write;     // store latched samples at the write slot
        logic acc_clr;   // clear the accumulators
        logic rd_en;     // issue one tap read
        logic advance;   // step the write slot
        logic load;      // move rounded sums to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_dp_sts;

endpackage

// ===== rtl/core/fird2_ram.sv =====
// ----------------------------------------------------------------------------
// fird2_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fird2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fird2_ctrl.sv =====
// ----------------------------------------------------------------------------
// fird2_ctrl: sequencer of the decimate-by-two FIR
// Tracks decimation phase and steps the datapath through the taps.
// ----------------------------------------------------------------------------
module fird2_ctrl #(
    parameter int TAPS = fird2_pkg::DEF_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_buffer_start,
    output logic                    o_in_ready,
    output fird2_pkg::t_dp_cmd      o_cmd,
    output logic [$clog2(TAPS)-1:0] o_tap,
    input  fird2_pkg::t_dp_sts      i_sts
);
    import fird2_pkg::*;

    localparam int TAP_W = $clog2(TAPS);

    t_state            r_state, n_state;
    logic [TAP_W-1:0]  r_cnt, n_cnt;
    logic              r_odd, n_odd;
    logic              r_emit, n_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_odd   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_odd   <= n_odd;
            r_emit  <= n_emit;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_odd   = r_odd;
        n_emit  = r_emit;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WRITE;
                    // buffer start forces an even frame
                    n_emit  = i_buffer_start | ~r_odd;
                    n_odd   = i_buffer_start | ~r_odd;
                end
            end
            S_WRITE: begin
                n_cnt   = '0;
                n_state = r_emit ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (r_cnt == TAP_W'(TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FLUSH;
                end else begin
                    n_cnt = r_cnt + TAP_W'(1);
                end
            end
            S_FLUSH: begin
                // drain the pipeline: read register to product, product to sum
                if (r_cnt == TAP_W'(1)) begin
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + TAP_W'(1);
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_WRITE: begin
                o_cmd.write   = 1'b1;
                o_cmd.acc_clr = 1'b1;
                o_cmd.advance = ~r_emit;
            end
            S_MAC: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.advance = (r_cnt == TAP_W'(TAPS - 1));
            end
            S_FLUSH: begin
            end
            S_LOAD: begin
                o_cmd.load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_tap = r_cnt;

endmodule

// ===== rtl/core/fird2_dp.sv =====
// ----------------------------------------------------------------------------
// fird2_dp: datapath of the decimate-by-two FIR
// Per-channel history RAM and multiply-accumulate lane, rounding, output reg.
// ----------------------------------------------------------------------------
module fird2_dp #(
    parameter int TAPS         = fird2_pkg::DEF_TAPS,
    parameter int CHANNELS     = fird2_pkg::DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = fird2_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fird2_pkg::t_dp_cmd             i_cmd,
    input  logic [$clog2(TAPS)-1:0]        i_tap,
    output fird2_pkg::t_dp_sts             o_sts,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch0,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch3,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch0,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch1,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch2,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch3
);
    import fird2_pkg::*;

    localparam int TAP_W  = $clog2(TAPS);
    localparam int LANES  = (CHANNELS < FIELD_CHANNELS) ? CHANNELS : FIELD_CHANNELS;
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 7;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

    logic signed [SAMPLE_WIDTH-1:0] in_arr [FIELD_CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_out  [FIELD_CHANNELS];
    logic                           r_out_valid;

    // write slot and history fill state
    logic [TAP_W-1:0] r_wp;
    logic             r_full;

    // tap read issue
    logic [TAP_W:0]              rd_sum;
    logic [TAP_W:0]              rd_wrap;
    logic [TAP_W-1:0]            rd_idx;
    logic                        rd_ok;
    logic                        r_p1_vld, r_p1_ok;
    logic signed [COEF_W-1:0]    r_p1_coef;
    logic                        r_p2_vld;

    assign in_arr[0] = i_in_ch0;
    assign in_arr[1] = i_in_ch1;
    assign in_arr[2] = i_in_ch2;
    assign in_arr[3] = i_in_ch3;

    // index of tap t: (wp - t) mod TAPS
    assign rd_sum  = {1'b0, r_wp} + (TAP_W + 1)'(TAPS) - {1'b0, i_tap};
    assign rd_wrap = rd_sum - (TAP_W + 1)'(TAPS);
    assign rd_idx  = (rd_sum >= (TAP_W + 1)'(TAPS)) ? rd_wrap[TAP_W-1:0] : rd_sum[TAP_W-1:0];
    // slots not yet written since reset read as zero
    assign rd_ok   = r_full || (rd_idx <= r_wp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            if (i_cmd.advance) begin
                if (r_wp == TAP_W'(TAPS - 1)) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + TAP_W'(1);
                end
            end
            r_p1_vld <= i_cmd.rd_en;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_p1_ok   <= rd_ok;
            r_p1_coef <= tap_coef(int'(i_tap), TAPS);
        end
    end

    // one lane per channel carried on a port
    for (genvar c = 0; c < LANES; c++) begin : g_lane
        logic signed [SAMPLE_WIDTH-1:0] r_smp;
        logic [SAMPLE_WIDTH-1:0]        rdata;
        logic signed [PROD_W-1:0]       prod;
        logic signed [PROD_W-1:0]       r_prod;
        logic signed [ACC_W-1:0]        r_acc;
        logic signed [ACC_W-1:0]        rnd;
        logic signed [SAMPLE_WIDTH-1:0] sat;

        fird2_ram #(
            .WIDTH (SAMPLE_WIDTH),
            .DEPTH (TAPS)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (i_cmd.write),
            .i_waddr (r_wp),
            .i_wdata (r_smp),
            .i_re    (i_cmd.rd_en),
            .i_raddr (rd_idx),
            .o_rdata (rdata)
        );

        // signed sample times signed coefficient
        assign prod = $signed(rdata) * r_p1_coef;

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                r_smp <= in_arr[c];
            end
            if (r_p1_vld) begin
                r_prod <= r_p1_ok ? prod : '0;
            end
            if (i_cmd.acc_clr) begin
                r_acc <= '0;
            end else if (r_p2_vld) begin
                r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
        end

        // round half up to Q1.15 then clamp
        always_comb begin
            rnd = (r_acc + RND_HALF) >>> COEF_FRAC;
            if (rnd > SAT_HI) begin
                sat = SAT_HI[SAMPLE_WIDTH-1:0];
            end else if (rnd < SAT_LO) begin
                sat = SAT_LO[SAMPLE_WIDTH-1:0];
            end else begin
                sat = rnd[SAMPLE_WIDTH-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_out[c] <= sat;
            end
        end
    end

    for (genvar c = LANES; c < FIELD_CHANNELS; c++) begin : g_idle
        assign r_out[c] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_ch0      = r_out[0];
    assign o_out_ch1      = r_out[1];
    assign o_out_ch2      = r_out[2];
    assign o_out_ch3      = r_out[3];

endmodule

// ===== rtl/core/fir_decimate_by_two.sv =====
// ----------------------------------------------------------------------------
// fir_decimate_by_two: multichannel low-pass FIR with decimation by two
// Symmetric TAPS-tap Q1.15 filter over four audio channels, one result
// frame for every even input frame.
// ----------------------------------------------------------------------------
// Each request is one audio frame of up to four channels. Every frame is
// written into its channel's history; on even frames (buffer_start forces
// a frame even, otherwise the phase alternates) one output frame follows,
// each channel the Q1.15 sum of the symmetric low-pass taps over the
// history, newest sample first, rounded half up and saturated. An odd
// frame is only written. For an even frame one multiply-accumulate per
// channel steps through the taps, one history RAM read per tap, followed
// by the pipeline flush and the output load. A finished frame waits in
// the output register while the next request is taken; a further result
// waits for that register to be emptied. History reads as zero until
// written, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fir_decimate_by_two #(
    parameter int TAPS         = fird2_pkg::DEF_TAPS,
    parameter int CHANNELS     = fird2_pkg::DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = fird2_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // frame in
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_buffer_start,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch0,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_ch3,
    // filtered frame out
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch0,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch1,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch2,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ch3
);
    import fird2_pkg::*;

    t_dp_cmd                  cmd;
    t_dp_sts                  sts;
    logic [$clog2(TAPS)-1:0]  tap;

    // sequencer: phase, tap count, handshake
    fird2_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_buffer_start (i_buffer_start),
        .o_in_ready     (o_in_ready),
        .o_cmd          (cmd),
        .o_tap          (tap),
        .i_sts          (sts)
    );

    // history, MAC lanes, rounding and output register
    fird2_dp #(
        .TAPS         (TAPS),
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_tap       (tap),
        .o_sts       (sts),
        .i_in_ch0    (i_in_ch0),
        .i_in_ch1    (i_in_ch1),
        .i_in_ch2    (i_in_ch2),
        .i_in_ch3    (i_in_ch3),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_ch0   (o_out_ch0),
        .o_out_ch1   (o_out_ch1),
        .o_out_ch2   (o_out_ch2),
        .o_out_ch3   (o_out_ch3)
    );

endmodule

// ===== tb/fir_decimate_by_two_test.sv =====
// ----------------------------------------------------------------------------
// fir_decimate_by_two_test: self-checking bench for the decimating FIR
// Drives audio frame requests through valid/ready, predicts every even-phase
// output frame with a behavioural low-pass model and checks each field.
// ----------------------------------------------------------------------------
module fir_decimate_by_two_test;

    localparam int TAPS       = fird2_pkg::DEF_TAPS;
    localparam int CHANS      = fird2_pkg::FIELD_CHANNELS;
    localparam int SW         = fird2_pkg::DEF_SAMPLE_WIDTH;
    localparam int IDLE_LIMIT = 2000;   // cycles with no handshake at all
    localparam int HOLD_LEN   = 300;    // long output back-pressure stretch
    localparam int RAND_REQS  = 750;

    // one audio frame, index 0 is channel 0
    typedef logic [CHANS-1:0][SW-1:0] frame_t;

    // ------------------------------------------------------------------------
    // Behavioural low-pass/decimate model and store of expected frames
    // ------------------------------------------------------------------------
    class decimated_frame_board;
        int          history [CHANS][TAPS];
        int          write_slot;
        bit          odd_phase;
        frame_t      expected_frames [$];
        int unsigned mismatches;

        function new();
            foreach (history[c, t]) history[c][t] = 0;
            write_slot = 0;
            odd_phase  = 1'b0;
            mismatches = 0;
        endfunction

        // symmetric Q1.15 weights, tap 0 is the newest sample
        function int tap_weight(int t);
            int h;
            h = (t < TAPS - 1 - t) ? t : TAPS - 1 - t;
            case (h)
                0:       return 17;
                1:       return -47;
                2:       return -166;
                3:       return -77;
                4:       return 368;
                5:       return 667;
                6:       return -16;
                7:       return -1485;
                8:       return -1808;
                9:       return 1080;
                10:      return 6634;
                11:      return 11218;
                default: return 0;
            endcase
        endfunction

        // exact sum, round half up, clamp to Q1.15
        function logic [SW-1:0] lowpass_sum(int c);
            longint acc;
            longint r;
            int     idx;
            acc = 0;
            for (int t = 0; t < TAPS; t++) begin
                idx = (write_slot + TAPS - t) % TAPS;
                acc += longint'(tap_weight(t)) * longint'(history[c][idx]);
            end
            r = (acc + 64'sd16384) >>> 15;
            if (r > 32767) r = 32767;
            else if (r < -32768) r = -32768;
            return r[SW-1:0];
        endfunction

        function void note_request(bit start, frame_t smp);
            frame_t want;
            if (start) odd_phase = 1'b0;
            for (int c = 0; c < CHANS; c++) history[c][write_slot] = $signed(smp[c]);
            if (!odd_phase) begin
                for (int c = 0; c < CHANS; c++) want[c] = lowpass_sum(c);
                expected_frames.push_back(want);
            end
            write_slot = (write_slot + 1) % TAPS;
            odd_phase  = !odd_phase;
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            bit     bad;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output frame %h", got);
                return;
            end
            want = expected_frames.pop_front();
            bad  = 1'b0;
            for (int c = 0; c < CHANS; c++) if (got[c] !== want[c]) bad = 1'b1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    for (int c = 0; c < CHANS; c++)
                        if (got[c] !== want[c])
                            $display("ch%0d mismatch: expected %0d, got %0d",
                                     c, $signed(want[c]), $signed(got[c]));
                end
            end
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_buffer_start = 1'b0;
    logic signed [SW-1:0] i_in_ch0 = '0;
    logic signed [SW-1:0] i_in_ch1 = '0;
    logic signed [SW-1:0] i_in_ch2 = '0;
    logic signed [SW-1:0] i_in_ch3 = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [SW-1:0] o_out_ch0;
    logic signed [SW-1:0] o_out_ch1;
    logic signed [SW-1:0] o_out_ch2;
    logic signed [SW-1:0] o_out_ch3;

    // idling control shared by both sides; hold_wanted asks the receiver
    // for one long back-pressure stretch
    bit gaps_on     = 1'b1;
    bit hold_wanted = 1'b0;

    decimated_frame_board board;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    fir_decimate_by_two #(
        .TAPS         (TAPS),
        .CHANNELS     (fird2_pkg::DEF_CHANNELS),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_buffer_start (i_buffer_start),
        .i_in_ch0       (i_in_ch0),
        .i_in_ch1       (i_in_ch1),
        .i_in_ch2       (i_in_ch2),
        .i_in_ch3       (i_in_ch3),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_ch0      (o_out_ch0),
        .o_out_ch1      (o_out_ch1),
        .o_out_ch2      (o_out_ch2),
        .o_out_ch3      (o_out_ch3)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. The output is
    // checked before the input is noted, as a frame leaving on this edge can
    // never belong to the request taken on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_frame({o_out_ch3, o_out_ch2, o_out_ch1, o_out_ch0});
            if (i_in_valid && o_in_ready)
                board.note_request(i_buffer_start,
                                   {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0});
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, or one long hold-off counted here
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_wanted) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_wanted = 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 15);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run once nothing has moved for too long
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender. Called at a falling edge, returns at the falling edge after
    // acceptance with valid still high, so back-to-back requests keep valid
    // up without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_request(input bit start, input frame_t smp);
        while (gaps_on && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_buffer_start <= start;
        i_in_ch0       <= smp[0];
        i_in_ch1       <= smp[1];
        i_in_ch2       <= smp[2];
        i_in_ch3       <= smp[3];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // style 0: full range, 1: extremes only, 2: small values, 3: any of these
    function automatic logic [SW-1:0] pick_sample(int style);
        logic [SW-1:0] v;
        int            s;
        s = (style == 3) ? $urandom_range(0, 2) : style;
        case (s)
            0: v = SW'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: v = SW'(int'($urandom_range(0, 511)) - 256);
        endcase
        return v;
    endfunction

    function automatic frame_t pick_frame(int style);
        frame_t f;
        for (int c = 0; c < CHANS; c++) f[c] = pick_sample(style);
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int  frames_sent;
        int  buf_len;
        int  style;
        bit  flagged;
        bit  start;
        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Impulse at full scale and at one half: the half values make every
        // odd weight land exactly on a rounding tie, positive and negative.
        send_request(1'b1, {16'hC000, 16'h4000, 16'h8000, 16'h7FFF});
        // a buffer start on what would be an odd frame forces it even
        send_request(1'b1, '0);
        repeat (10) send_request(1'b0, '0);
        // constant full scale on two channels drives the sum past the Q1.15 range
        for (int k = 0; k < 14; k++)
            send_request(1'b0, {pick_sample(0), k[0] ? 16'h7FFF : 16'h8000,
                                16'h8000, 16'h7FFF});

        // Random buffers of random length; a few lack their start flag and
        // a few carry a stray one mid-buffer.
        frames_sent = 0;
        while (frames_sent < RAND_REQS) begin
            buf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80)
                                                  : $urandom_range(1, 40);
            style   = $urandom_range(0, 3);
            flagged = ($urandom_range(0, 7) != 0);
            for (int i = 0; i < buf_len && frames_sent < RAND_REQS; i++) begin
                if (frames_sent == 200) hold_wanted = 1'b1;
                if (frames_sent == 400) begin
                    // let every expected frame drain before going on
                    i_in_valid <= 1'b0;
                    do @(negedge i_clk); while (board.pending() != 0);
                end
                if (frames_sent == 500) gaps_on = 1'b0;
                if (frames_sent == 650) gaps_on = 1'b1;
                start = (i == 0 && flagged) || ($urandom_range(0, 29) == 0);
                send_request(start, pick_frame(style));
                frames_sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fird2_pkg.sv
rtl/core/fird2_ram.sv
rtl/core/fird2_ctrl.sv
rtl/core/fird2_dp.sv
rtl/core/fir_decimate_by_two.sv
tb/fir_decimate_by_two_test.sv
